// ===== sv/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared constants, codes and types for the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

    // table geometry
    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int ECOUNT_W = 7;

    // operation codes
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // one stored entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // request from the sequencer to the memory
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

endpackage

// ===== sv/skvt_ram.sv =====
// ----------------------------------------------------------------------------
// skvt_ram
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module skvt_ram (
    input  logic                aclk,
    input  skvt_pkg::mem_req_t  req,
    output skvt_pkg::entry_t    rd_data
);

    skvt_pkg::entry_t mem [skvt_pkg::DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== sv/sorted_key_value_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_value_table_top
// Table of up to DEPTH key/value pairs held in ascending key order.
// ----------------------------------------------------------------------------
// Usage: each input beat on s_axis carries one operation (lookup, set or
// remove) and produces exactly one result beat on m_axis.
// The entries live in one synchronous memory. An operation first scans the
// valid entries from index 0, one read at a time (read, then compare),
// until it meets a key not below the requested one; a set of a new key then
// moves the tail up one place, a remove moves it down, one entry at a time
// (read, then write). One operation is in flight at a time and the input is
// ready again in the cycle after the result beat is taken.
// Reset clears the entry count, sequencer state, output valid and read flag;
// memory contents need no clearing as entries above the count are never read.
// The result sits in an output register; while the receiver stalls the block
// holds it and accepts no new beat until it has been taken.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] mode, [33:2] key, [65:34] new_value, [97:66] fallback, zero pad
    input  logic [103:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] found, [32:1] read_value, [33] full_res, [40:34] entry_count, pad
    output logic [47:0] m_axis_tdata
);

    localparam int AW = skvt_pkg::ADDR_W;
    localparam int CW = skvt_pkg::CNT_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_INS   = 3'd3;
    localparam logic [2:0] ST_DEL   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;   // insertion position
    logic [1:0]  mode_reg;
    logic [31:0] key_reg, nval_reg, fb_reg;
    logic        found_reg, found_next;
    logic [31:0] rval_reg, rval_next;
    logic        full_reg, full_next;
    logic        ovalid_reg, ovalid_next;
    logic        pend_reg, pend_next;   // a read was issued last cycle
    logic [CW-1:0] pidx_reg, pidx_next; // index the entry read last cycle is moved to

    skvt_pkg::mem_req_t req;
    skvt_pkg::entry_t   rdat;

    skvt_ram u_ram (.aclk(aclk), .req(req), .rd_data(rdat));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, count_reg[skvt_pkg::ECOUNT_W-1:0], full_reg,
                            rval_reg, found_reg};

    // capture request fields
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            mode_reg <= s_axis_tdata[1:0];
            key_reg  <= s_axis_tdata[33:2];
            nval_reg <= s_axis_tdata[65:34];
            fb_reg   <= s_axis_tdata[97:66];
        end
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        rval_next   = rval_reg;
        full_next   = full_reg;
        ovalid_next = ovalid_reg;
        pend_next   = 1'b0;
        pidx_next   = pidx_reg;
        req         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    full_next  = 1'b0;
                    rval_next  = s_axis_tdata[97:66];
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // examine the entry read last cycle, else stop at the end or issue the next read
                if (pend_reg) begin
                    if (rdat.key >= key_reg) begin
                        found_next = (rdat.key == key_reg);
                        state_next = ST_CHECK;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else if (idx_reg >= count_reg) begin
                    state_next = ST_CHECK;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_reg[AW-1:0];
                    pend_next   = 1'b1;
                end
            end
            ST_CHECK: begin
                // idx_reg is the first position not below the key
                state_next = ST_OUT;
                if (mode_reg == skvt_pkg::MODE_SET) begin
                    if (found_reg) begin
                        req.wr_en         = 1'b1;
                        req.wr_addr       = idx_reg[AW-1:0];
                        req.wr_data.key   = key_reg;
                        req.wr_data.value = nval_reg;
                    end else if (count_reg >= CW'(skvt_pkg::DEPTH)) begin
                        full_next = 1'b1;
                    end else begin
                        pos_next   = idx_reg;
                        idx_next   = count_reg;
                        state_next = ST_INS;
                    end
                end else if (mode_reg == skvt_pkg::MODE_REMOVE) begin
                    if (found_reg) begin
                        state_next = ST_DEL;
                    end
                end else if (found_reg) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_reg[AW-1:0];
                    pend_next   = 1'b1;
                end
            end
            ST_INS: begin
                // walk down from the end: move entry i-1 to i, read then write
                pidx_next = idx_reg;
                if (pend_reg) begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = pidx_reg[AW-1:0];
                    req.wr_data = rdat;
                    idx_next    = idx_reg - 1'b1;
                end else if (idx_reg == pos_reg) begin
                    // gap reached: drop the new entry in
                    req.wr_en         = 1'b1;
                    req.wr_addr       = idx_reg[AW-1:0];
                    req.wr_data.key   = key_reg;
                    req.wr_data.value = nval_reg;
                    count_next        = count_reg + 1'b1;
                    state_next        = ST_OUT;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = AW'(idx_reg - 1'b1);
                    pend_next   = 1'b1;
                end
            end
            ST_DEL: begin
                // walk up: move entry i+1 to i
                pidx_next = idx_reg;
                if (pend_reg) begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = pidx_reg[AW-1:0];
                    req.wr_data = rdat;
                    idx_next    = idx_reg + 1'b1;
                end else if (CW'(idx_reg + 1'b1) >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_OUT;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = AW'(idx_reg + 1'b1);
                    pend_next   = 1'b1;
                end
            end
            ST_OUT: begin
                // lookup hit: the value read in the check step lands now
                if (pend_reg) begin
                    rval_next = rdat.value;
                end
                if (!ovalid_reg) begin
                    ovalid_next = 1'b1;
                end else if (m_axis_tready) begin
                    ovalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        rval_reg  <= rval_next;
        full_reg  <= full_next;
        pidx_reg  <= pidx_next;
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(skvt_pkg::DEPTH))
        else $error("entry count above depth");
    a_full_only_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && full_reg) |-> (!found_reg && count_reg == CW'(skvt_pkg::DEPTH)))
        else $error("full flag without a full table");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && !m_axis_tready) |=> (ovalid_reg && $stable(count_reg)))
        else $error("result changed while stalled");

endmodule
